// ===== src/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define OMD_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication.
`define OMD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define OMD_ASSERT_NOW(label, clk, rst_n, pre, post, msg)
`define OMD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/omd_pkg.sv =====
// Shared types and constants of the OSC message decoder.
// No dependencies; used by omd_front, omd_queue, omd_back and the top level.
`default_nettype none

package omd_pkg;

    // Result kinds, also used as queue op codes
    localparam logic [2:0] KIND_ADDR     = 3'd0;
    localparam logic [2:0] KIND_INT      = 3'd1;
    localparam logic [2:0] KIND_FLOAT    = 3'd2;
    localparam logic [2:0] KIND_STR_CHAR = 3'd3;
    localparam logic [2:0] KIND_STR_END  = 3'd4;
    localparam logic [2:0] KIND_STATUS   = 3'd5;
    // Queue-only ops: T and F tags, expanded to float results in the back end
    localparam logic [2:0] OP_TRUE       = 3'd6;
    localparam logic [2:0] OP_FALSE      = 3'd7;

    // Message status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
    localparam logic [2:0] ST_BAD_TAGS  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_TOO_MANY  = 3'd5;

    // Stored tag codes
    localparam logic [2:0] TAG_FLOAT = 3'd0;
    localparam logic [2:0] TAG_INT   = 3'd1;
    localparam logic [2:0] TAG_STR   = 3'd2;
    localparam logic [2:0] TAG_TRUE  = 3'd3;
    localparam logic [2:0] TAG_FALSE = 3'd4;
    localparam logic [2:0] TAG_BLOB  = 3'd5;
    localparam logic [2:0] TAG_BAD   = 3'd6;

    // Characters
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_LC_I  = 8'h69;
    localparam logic [7:0] CHAR_LC_S  = 8'h73;
    localparam logic [7:0] CHAR_UC_T  = 8'h54;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_LC_B  = 8'h62;

    localparam logic [31:0] FLOAT_ONE    = 32'h3F80_0000;
    localparam logic [31:0] FLOAT_ZERO   = 32'h0000_0000;
    localparam logic [31:0] BLOB_LEN_MAX = 32'hFFFF_FFFC;

    // Queue between front and back end; must be a power of two
    localparam int QUEUE_DEPTH = 4;

    // One queued operation
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] data;
        logic [3:0]  idx;
        logic        last;
    } entry_t;

endpackage

`default_nettype wire

// ===== src/omd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module omd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/omd_front.sv =====
// Front end: accepts packet bytes, tracks the message phase, stores tags and
// walks runs of T/F tags. Depends on omd_pkg and omd_ram.
`default_nettype none

module omd_front #(
    parameter int MAX_TAGS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_push,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_end,
    output logic                 in_full,
    input  wire logic            q_full,
    output logic                 q_push,
    output omd_pkg::entry_t      q_entry
);

    localparam int CW = $clog2(MAX_TAGS + 1);
    localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TAGS);

    // Message phases
    localparam logic [2:0] PH_ADDR_FIRST = 3'd0;
    localparam logic [2:0] PH_ADDR_BODY  = 3'd1;
    localparam logic [2:0] PH_ADDR_PAD   = 3'd2;
    localparam logic [2:0] PH_TAG_FIRST  = 3'd3;
    localparam logic [2:0] PH_TAG_BODY   = 3'd4;
    localparam logic [2:0] PH_TAG_PAD    = 3'd5;
    localparam logic [2:0] PH_ARGS       = 3'd6;
    localparam logic [2:0] PH_DONE       = 3'd7;

    // Sequencer states
    localparam logic [1:0] SQ_ACCEPT = 2'd0;
    localparam logic [1:0] SQ_WALK   = 2'd1;
    localparam logic [1:0] SQ_STATUS = 2'd2;

    function automatic logic [2:0] tag_code(input logic [7:0] b);
        logic [2:0] code;
        case (b)
            omd_pkg::CHAR_LC_F: code = omd_pkg::TAG_FLOAT;
            omd_pkg::CHAR_LC_I: code = omd_pkg::TAG_INT;
            omd_pkg::CHAR_LC_S: code = omd_pkg::TAG_STR;
            omd_pkg::CHAR_UC_T: code = omd_pkg::TAG_TRUE;
            omd_pkg::CHAR_UC_F: code = omd_pkg::TAG_FALSE;
            omd_pkg::CHAR_LC_B: code = omd_pkg::TAG_BLOB;
            default:            code = omd_pkg::TAG_BAD;
        endcase
        return code;
    endfunction

    // Final status: an unfinished message counts as truncated, unless it ends right after the address
    function automatic logic [2:0] status_of(input logic [2:0] err, input logic [2:0] ph);
        logic [2:0] st;
        st = err;
        if (err == omd_pkg::ST_OK && ph != PH_DONE && ph != PH_TAG_FIRST)
        begin
            st = omd_pkg::ST_TRUNCATED;
        end
        return st;
    endfunction

    logic [1:0]      seq_reg, seq_next;
    logic [2:0]      phase_reg, phase_next;
    logic [1:0]      align_reg, align_next;
    logic [31:0]     shift_reg, shift_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [31:0]     skip_reg, skip_next;
    logic [2:0]      err_reg, err_next;
    logic [2:0]      cur_tag_reg, cur_tag_next;
    logic            last_reg, last_next;
    logic            pend_valid_reg, pend_valid_next;
    omd_pkg::entry_t pend_reg, pend_next;

    logic            accept;
    logic            emit;
    logic [2:0]      e_op;
    logic [31:0]     e_data;
    logic            walk_go;
    logic            clear;
    logic            tag_wr;
    logic [2:0]      ram_rdata;
    logic            walk_in_range;
    logic            walk_tf;
    logic [1:0]      pad2;
    logic [31:0]     pad_v;
    logic [31:0]     skip_dec;
    logic [31:0]     word_v;
    logic [31:0]     blob_len;
    logic [CW+3:0]   ptr_ext;
    logic [3:0]      ptr_idx;

    // Tag store
    omd_ram #(
        .WIDTH (3),
        .DEPTH (MAX_TAGS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (tag_code(in_byte)),
        .rd_addr (ptr_next[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Datapath helpers
    assign pad2          = 2'd3 - align_reg;
    assign pad_v         = {30'b0, pad2};
    assign skip_dec      = skip_reg - 32'd1;
    assign word_v        = {shift_reg[23:0], in_byte};
    assign blob_len      = (word_v + 32'd3) & ~32'd3;
    assign ptr_ext       = {4'b0, ptr_reg};
    assign ptr_idx       = ptr_ext[3:0];
    assign walk_in_range = (ptr_reg < count_reg);
    assign walk_tf       = (ram_rdata == omd_pkg::TAG_TRUE) || (ram_rdata == omd_pkg::TAG_FALSE);

    assign in_full = (seq_reg != SQ_ACCEPT) || q_full;
    assign accept  = in_push && !in_full;

    // Per-byte parse
    always_comb
    begin
        phase_next   = phase_reg;
        align_next   = align_reg;
        shift_next   = shift_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        skip_next    = skip_reg;
        err_next     = err_reg;
        cur_tag_next = cur_tag_reg;
        emit         = 1'b0;
        e_op         = omd_pkg::KIND_ADDR;
        e_data       = 32'b0;
        walk_go      = 1'b0;
        tag_wr       = 1'b0;
        if (accept)
        begin
            align_next = align_reg + 2'd1;
            unique case (phase_reg)
                PH_ADDR_FIRST:
                begin
                    if (in_byte != omd_pkg::CHAR_SLASH)
                    begin
                        err_next   = omd_pkg::ST_BAD_ADDR;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        e_data     = {24'b0, in_byte};
                        phase_next = PH_ADDR_BODY;
                    end
                end
                PH_ADDR_BODY:
                begin
                    if (in_byte != 8'd0)
                    begin
                        emit   = 1'b1;
                        e_data = {24'b0, in_byte};
                    end
                    else
                    begin
                        skip_next  = pad_v;
                        phase_next = (pad2 != 2'd0) ? PH_ADDR_PAD : PH_TAG_FIRST;
                    end
                end
                PH_ADDR_PAD:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        phase_next = PH_TAG_FIRST;
                    end
                end
                PH_TAG_FIRST:
                begin
                    if (in_byte != omd_pkg::CHAR_COMMA)
                    begin
                        err_next   = omd_pkg::ST_BAD_TAGS;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_TAG_BODY;
                    end
                end
                PH_TAG_BODY:
                begin
                    if (in_byte == 8'd0)
                    begin
                        skip_next = pad_v;
                        if (pad2 != 2'd0)
                        begin
                            phase_next = PH_TAG_PAD;
                        end
                        else
                        begin
                            ptr_next = '0;
                            walk_go  = 1'b1;
                        end
                    end
                    else if (count_reg >= MAX_CNT)
                    begin
                        err_next   = omd_pkg::ST_TOO_MANY;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        tag_wr     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                PH_TAG_PAD:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        ptr_next = '0;
                        walk_go  = 1'b1;
                    end
                end
                PH_ARGS:
                begin
                    if (cur_tag_reg == omd_pkg::TAG_STR)
                    begin
                        if (skip_reg != 32'd0)
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == 32'd0)
                            begin
                                ptr_next = ptr_reg + 1'b1;
                                walk_go  = 1'b1;
                            end
                        end
                        else if (in_byte == 8'd0)
                        begin
                            emit      = 1'b1;
                            e_op      = omd_pkg::KIND_STR_END;
                            skip_next = pad_v;
                            if (pad2 == 2'd0)
                            begin
                                ptr_next = ptr_reg + 1'b1;
                                walk_go  = 1'b1;
                            end
                        end
                        else
                        begin
                            emit   = 1'b1;
                            e_op   = omd_pkg::KIND_STR_CHAR;
                            e_data = {24'b0, in_byte};
                        end
                    end
                    else if (cur_tag_reg == omd_pkg::TAG_BLOB)
                    begin
                        if (skip_reg != 32'd0)
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == 32'd0)
                            begin
                                ptr_next = ptr_reg + 1'b1;
                                walk_go  = 1'b1;
                            end
                        end
                        else
                        begin
                            shift_next = word_v;
                            if (align_reg == 2'd3)
                            begin
                                if (word_v > omd_pkg::BLOB_LEN_MAX)
                                begin
                                    err_next   = omd_pkg::ST_TRUNCATED;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    skip_next = blob_len;
                                    if (blob_len == 32'd0)
                                    begin
                                        ptr_next = ptr_reg + 1'b1;
                                        walk_go  = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    else
                    begin
                        // int or float word, big-endian
                        shift_next = word_v;
                        if (align_reg == 2'd3)
                        begin
                            emit     = 1'b1;
                            e_op     = (cur_tag_reg == omd_pkg::TAG_INT) ?
                                       omd_pkg::KIND_INT : omd_pkg::KIND_FLOAT;
                            e_data   = word_v;
                            ptr_next = ptr_reg + 1'b1;
                            walk_go  = 1'b1;
                        end
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
        else if (seq_reg == SQ_WALK && !q_full)
        begin
            // One tag per cycle while the queue has room; read data belongs to ptr_reg
            if (walk_in_range && walk_tf)
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            else if (walk_in_range && ram_rdata == omd_pkg::TAG_BAD)
            begin
                err_next   = omd_pkg::ST_UNKNOWN;
                phase_next = PH_DONE;
            end
            else if (walk_in_range)
            begin
                phase_next   = PH_ARGS;
                cur_tag_next = ram_rdata;
                shift_next   = 32'b0;
                skip_next    = 32'b0;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end
    end

    // Result sequencing and run_last tracking
    always_comb
    begin
        seq_next        = seq_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        q_push          = 1'b0;
        q_entry         = '{op: e_op, data: e_data, idx: 4'd0, last: 1'b0};
        clear           = 1'b0;
        if (e_op != omd_pkg::KIND_ADDR)
        begin
            q_entry.idx = ptr_idx;
        end
        unique case (seq_reg)
            SQ_ACCEPT:
            begin
                if (accept)
                begin
                    if (walk_go)
                    begin
                        seq_next  = SQ_WALK;
                        last_next = in_end;
                        if (emit)
                        begin
                            pend_valid_next = 1'b1;
                            pend_next       = q_entry;
                        end
                    end
                    else if (emit)
                    begin
                        q_push       = 1'b1;
                        q_entry.last = !in_end;
                        if (in_end)
                        begin
                            seq_next = SQ_STATUS;
                        end
                    end
                    else if (in_end)
                    begin
                        q_push  = 1'b1;
                        q_entry = '{op: omd_pkg::KIND_STATUS,
                                    data: {29'b0, status_of(err_next, phase_next)},
                                    idx: 4'd0, last: 1'b1};
                        clear   = 1'b1;
                    end
                end
            end
            SQ_WALK:
            begin
                if (!q_full)
                begin
                    q_push  = pend_valid_reg;
                    q_entry = pend_reg;
                    if (walk_in_range && walk_tf)
                    begin
                        q_entry.last    = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_next       = '{op: (ram_rdata == omd_pkg::TAG_TRUE) ?
                                                omd_pkg::OP_TRUE : omd_pkg::OP_FALSE,
                                            data: 32'b0, idx: ptr_idx, last: 1'b0};
                    end
                    else
                    begin
                        q_entry.last    = !last_reg;
                        pend_valid_next = 1'b0;
                        seq_next        = last_reg ? SQ_STATUS : SQ_ACCEPT;
                    end
                end
            end
            SQ_STATUS:
            begin
                if (!q_full)
                begin
                    q_push   = 1'b1;
                    q_entry  = '{op: omd_pkg::KIND_STATUS,
                                 data: {29'b0, status_of(err_reg, phase_reg)},
                                 idx: 4'd0, last: 1'b1};
                    clear    = 1'b1;
                    seq_next = SQ_ACCEPT;
                end
            end
            default:
            begin
                seq_next = SQ_ACCEPT;
            end
        endcase
    end

    // Control registers; packet end returns the parse state to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= SQ_ACCEPT;
            phase_reg      <= PH_ADDR_FIRST;
            align_reg      <= 2'd0;
            shift_reg      <= 32'b0;
            count_reg      <= '0;
            ptr_reg        <= '0;
            skip_reg       <= 32'b0;
            err_reg        <= omd_pkg::ST_OK;
            last_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg        <= seq_next;
            last_reg       <= last_next;
            pend_valid_reg <= pend_valid_next;
            if (clear)
            begin
                phase_reg <= PH_ADDR_FIRST;
                align_reg <= 2'd0;
                shift_reg <= 32'b0;
                count_reg <= '0;
                ptr_reg   <= '0;
                skip_reg  <= 32'b0;
                err_reg   <= omd_pkg::ST_OK;
            end
            else
            begin
                phase_reg <= phase_next;
                align_reg <= align_next;
                shift_reg <= shift_next;
                count_reg <= count_next;
                ptr_reg   <= ptr_next;
                skip_reg  <= skip_next;
                err_reg   <= err_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_tag_reg <= cur_tag_next;
        pend_reg    <= pend_next;
    end

endmodule

`default_nettype wire

// ===== src/omd_queue.sv =====
// Short FIFO of decoded operations between the front and back ends.
// Depends on omd_pkg.
`default_nettype none

module omd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire omd_pkg::entry_t  push_entry,
    output logic                  full,
    input  wire logic             pop,
    output omd_pkg::entry_t       pop_entry,
    output logic                  empty
);

    localparam int QAW = $clog2(omd_pkg::QUEUE_DEPTH);
    localparam logic [QAW:0] DEPTH_CNT = (QAW + 1)'(omd_pkg::QUEUE_DEPTH);

    omd_pkg::entry_t slot_reg [omd_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/omd_back.sv =====
// Back end: expands queued operations into result items and holds the
// output register of the result channel. Depends on omd_pkg.
`default_nettype none

module omd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire omd_pkg::entry_t  q_entry,
    output logic                  q_pop,
    output logic [2:0]            kind,
    output logic [31:0]           value,
    output logic [3:0]            arg_index,
    output logic [2:0]            status,
    output logic                  run_last,
    output logic                  empty,
    input  wire logic             pop
);

    logic        out_valid_reg;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] value_reg, value_next;
    logic [3:0]  idx_reg, idx_next;
    logic [2:0]  status_reg, status_next;
    logic        last_reg;

    assign q_pop = !q_empty && (!out_valid_reg || pop);

    // Op decode
    always_comb
    begin
        kind_next   = q_entry.op;
        value_next  = q_entry.data;
        idx_next    = q_entry.idx;
        status_next = omd_pkg::ST_OK;
        unique case (q_entry.op) inside
            omd_pkg::KIND_ADDR, omd_pkg::KIND_INT, omd_pkg::KIND_FLOAT,
            omd_pkg::KIND_STR_CHAR:
            begin
            end
            omd_pkg::KIND_STR_END:
            begin
                value_next = 32'b0;
            end
            omd_pkg::KIND_STATUS:
            begin
                value_next  = 32'b0;
                idx_next    = 4'd0;
                status_next = q_entry.data[2:0];
            end
            omd_pkg::OP_TRUE:
            begin
                kind_next  = omd_pkg::KIND_FLOAT;
                value_next = omd_pkg::FLOAT_ONE;
            end
            omd_pkg::OP_FALSE:
            begin
                kind_next  = omd_pkg::KIND_FLOAT;
                value_next = omd_pkg::FLOAT_ZERO;
            end
            default:
            begin
            end
        endcase
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            last_reg   <= q_entry.last;
        end
    end

    assign empty     = !out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign arg_index = idx_reg;
    assign status    = status_reg;
    assign run_last  = last_reg;

endmodule

`default_nettype wire

// ===== src/osc_message_decoder_core.sv =====
// Top level of the OSC message decoder: front end, operation queue, back end.
// Depends on omd_pkg, omd_front, omd_queue, omd_back and assert_macros.svh.
//
// Decodes one OSC message per packet, fed as one byte per transfer with
// packet_end on the final byte. Plain bytes are taken at one per cycle. A byte
// that completes an argument (or ends the tag string) starts a walk over the
// stored tags: the front end then reads one tag per cycle from the tag RAM
// while the queue has room, and that byte holds the input until the walk has
// passed every T/F tag in its run. A packet_end byte that yields a data result
// or starts a walk is followed by a separate status step, during which input
// is held. Input also stalls while the 4-entry operation queue is full, which
// follows the result side's pop rate. The tag RAM has no reset and needs no
// clearing pass; only tags written in the current packet are ever read. A
// message whose status result is not ok is to be discarded by the consumer.
`default_nettype none

`include "assert_macros.svh"

module osc_message_decoder_core #(
    parameter int MAX_TAGS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  data_byte,
    input  wire logic        packet_end,
    input  wire logic        push,
    output logic             full,
    output logic [2:0]       kind,
    output logic [31:0]      value,
    output logic [3:0]       arg_index,
    output logic [2:0]       status,
    output logic             run_last,
    output logic             empty,
    input  wire logic        pop
);

    logic            q_push;
    omd_pkg::entry_t q_in;
    logic            q_full;
    logic            q_pop;
    omd_pkg::entry_t q_out;
    logic            q_empty;

    // Parse and tag walk
    omd_front #(
        .MAX_TAGS (MAX_TAGS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_push (push),
        .in_byte (data_byte),
        .in_end  (packet_end),
        .in_full (full),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    // Operation queue
    omd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .empty      (q_empty)
    );

    // Result expansion and output register
    omd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (q_out),
        .q_pop     (q_pop),
        .kind      (kind),
        .value     (value),
        .arg_index (arg_index),
        .status    (status),
        .run_last  (run_last),
        .empty     (empty),
        .pop       (pop)
    );

    // Checks
    `OMD_ASSERT_NOW(a_no_overflow, clk, rst_n, q_push, !q_full, "queue push while full")
    `OMD_ASSERT_NEXT(a_out_fill, clk, rst_n, !q_empty && empty, !empty, "output not refilled")
    `OMD_ASSERT_NOW(a_status_last, clk, rst_n, !empty && kind == omd_pkg::KIND_STATUS, run_last, "status result not last of its byte")
    `OMD_ASSERT_NOW(a_status_only, clk, rst_n, !empty && kind != omd_pkg::KIND_STATUS, status == omd_pkg::ST_OK, "status set on data result")

endmodule

`default_nettype wire

// ===== sim/tb_osc_message_decoder_core.sv =====
// Self-checking testbench for osc_message_decoder_core: byte transfers in, decoded results out.
// Depends on omd_pkg and the decoder RTL; the expected results come from a predictor built into
// the scoreboard class below.
`timescale 1ns / 1ps

module tb_osc_message_decoder_core;

    localparam int TAG_SLOTS = 16;
    localparam int BYTES_PER_PHASE = 105;
    localparam int DRAIN_CYCLES = 40;

    // Parser position within one packet
    typedef enum logic [2:0] {
        AWAIT_SLASH,
        ADDR_TEXT,
        ADDR_ALIGN,
        AWAIT_COMMA,
        TAG_TEXT,
        TAG_ALIGN,
        ARG_DATA,
        MSG_DONE
    } parse_phase_t;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [3:0]  arg_index;
        logic [2:0]  status;
        logic        run_last;
    } decode_result_t;

    // Scoreboard: predicts the results of each accepted byte and checks the popped ones
    class osc_result_board_t;
        parse_phase_t   phase;
        logic [1:0]     align;
        logic [31:0]    shift;
        logic [2:0]     tags [TAG_SLOTS];
        int unsigned    tag_count;
        int unsigned    tag_ptr;
        logic [31:0]    skip;
        logic [2:0]     err;
        decode_result_t step_out[$];
        decode_result_t pending_results[$];
        int             mismatch_count;
        int             checked_count;
        int             status_tally[6];

        function new();
            foreach (tags[i]) tags[i] = omd_pkg::TAG_FLOAT;
            foreach (status_tally[i]) status_tally[i] = 0;
            mismatch_count = 0;
            checked_count = 0;
            clear();
        endfunction

        function void clear();
            phase = AWAIT_SLASH;
            align = 2'd0;
            shift = '0;
            tag_count = 0;
            tag_ptr = 0;
            skip = '0;
            err = omd_pkg::ST_OK;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void emit(logic [2:0] k, logic [31:0] v, logic [3:0] idx, logic [2:0] st);
            decode_result_t r;
            r.kind = k;
            r.value = v;
            r.arg_index = idx;
            r.status = st;
            r.run_last = 1'b0;
            step_out = {step_out, r};
        endfunction

        function void abort(logic [2:0] code);
            err = code;
            phase = MSG_DONE;
        endfunction

        function logic [2:0] tag_of(logic [7:0] b);
            case (b)
                omd_pkg::CHAR_LC_F: return omd_pkg::TAG_FLOAT;
                omd_pkg::CHAR_LC_I: return omd_pkg::TAG_INT;
                omd_pkg::CHAR_LC_S: return omd_pkg::TAG_STR;
                omd_pkg::CHAR_UC_T: return omd_pkg::TAG_TRUE;
                omd_pkg::CHAR_UC_F: return omd_pkg::TAG_FALSE;
                omd_pkg::CHAR_LC_B: return omd_pkg::TAG_BLOB;
                default:            return omd_pkg::TAG_BAD;
            endcase
        endfunction

        // T and F tags come out at once; stop at the first tag that needs bytes or is unknown
        function void walk_tags();
            logic [2:0] t;
            while (tag_ptr < tag_count)
            begin
                t = tags[tag_ptr];
                if (t == omd_pkg::TAG_TRUE || t == omd_pkg::TAG_FALSE)
                begin
                    emit(omd_pkg::KIND_FLOAT,
                         (t == omd_pkg::TAG_TRUE) ? omd_pkg::FLOAT_ONE : omd_pkg::FLOAT_ZERO,
                         4'(tag_ptr), omd_pkg::ST_OK);
                    tag_ptr++;
                end
                else if (t == omd_pkg::TAG_BAD)
                begin
                    abort(omd_pkg::ST_UNKNOWN);
                    return;
                end
                else
                begin
                    phase = ARG_DATA;
                    shift = '0;
                    skip = '0;
                    return;
                end
            end
            phase = MSG_DONE;
        endfunction

        function void next_tag();
            tag_ptr++;
            walk_tags();
        endfunction

        // Accepted input transfer: work out the results it causes
        function void note_byte(logic [7:0] b, logic last);
            logic [1:0] pos;
            logic [2:0] t;
            logic [2:0] st;
            pos = align;
            align = align + 2'd1;
            step_out.delete();
            case (phase)
                AWAIT_SLASH:
                begin
                    if (b != omd_pkg::CHAR_SLASH) abort(omd_pkg::ST_BAD_ADDR);
                    else
                    begin
                        emit(omd_pkg::KIND_ADDR, {24'd0, b}, 4'd0, omd_pkg::ST_OK);
                        phase = ADDR_TEXT;
                    end
                end
                ADDR_TEXT:
                begin
                    if (b != 8'd0) emit(omd_pkg::KIND_ADDR, {24'd0, b}, 4'd0, omd_pkg::ST_OK);
                    else
                    begin
                        skip = 32'd3 - pos;
                        phase = (skip != 0) ? ADDR_ALIGN : AWAIT_COMMA;
                    end
                end
                ADDR_ALIGN:
                begin
                    skip = skip - 1;
                    if (skip == 0) phase = AWAIT_COMMA;
                end
                AWAIT_COMMA:
                begin
                    if (b != omd_pkg::CHAR_COMMA) abort(omd_pkg::ST_BAD_TAGS);
                    else phase = TAG_TEXT;
                end
                TAG_TEXT:
                begin
                    if (b == 8'd0)
                    begin
                        skip = 32'd3 - pos;
                        if (skip != 0) phase = TAG_ALIGN;
                        else
                        begin
                            tag_ptr = 0;
                            walk_tags();
                        end
                    end
                    else if (tag_count >= TAG_SLOTS) abort(omd_pkg::ST_TOO_MANY);
                    else
                    begin
                        tags[tag_count] = tag_of(b);
                        tag_count++;
                    end
                end
                TAG_ALIGN:
                begin
                    skip = skip - 1;
                    if (skip == 0)
                    begin
                        tag_ptr = 0;
                        walk_tags();
                    end
                end
                ARG_DATA:
                begin
                    t = tags[tag_ptr];
                    if (t == omd_pkg::TAG_STR)
                    begin
                        if (skip != 0)
                        begin
                            skip = skip - 1;
                            if (skip == 0) next_tag();
                        end
                        else if (b == 8'd0)
                        begin
                            emit(omd_pkg::KIND_STR_END, '0, 4'(tag_ptr), omd_pkg::ST_OK);
                            skip = 32'd3 - pos;
                            if (skip == 0) next_tag();
                        end
                        else
                            emit(omd_pkg::KIND_STR_CHAR, {24'd0, b}, 4'(tag_ptr), omd_pkg::ST_OK);
                    end
                    else if (t == omd_pkg::TAG_BLOB)
                    begin
                        if (skip != 0)
                        begin
                            skip = skip - 1;
                            if (skip == 0) next_tag();
                        end
                        else
                        begin
                            shift = {shift[23:0], b};
                            if (pos == 2'd3)
                            begin
                                // length too large for any packet ends the message at once
                                if (shift > omd_pkg::BLOB_LEN_MAX) abort(omd_pkg::ST_TRUNCATED);
                                else
                                begin
                                    skip = (shift + 32'd3) & ~32'd3;
                                    if (skip == 0) next_tag();
                                end
                            end
                        end
                    end
                    else
                    begin
                        // int or float word, big-endian
                        shift = {shift[23:0], b};
                        if (pos == 2'd3)
                        begin
                            emit((t == omd_pkg::TAG_INT) ? omd_pkg::KIND_INT : omd_pkg::KIND_FLOAT,
                                 shift, 4'(tag_ptr), omd_pkg::ST_OK);
                            next_tag();
                        end
                    end
                end
                default: ;
            endcase

            // Status closes the packet; ending right after the address is fine
            if (last)
            begin
                st = err;
                if (st == omd_pkg::ST_OK && phase != MSG_DONE && phase != AWAIT_COMMA)
                    st = omd_pkg::ST_TRUNCATED;
                emit(omd_pkg::KIND_STATUS, '0, 4'd0, st);
                status_tally[st]++;
                clear();
            end
            if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
            pending_results = {pending_results, step_out};
        endfunction

        // Accepted output transfer: compare with the oldest prediction
        function void check_result(logic [2:0] k, logic [31:0] v, logic [3:0] idx,
                                   logic [2:0] st, logic rl);
            decode_result_t want;
            checked_count++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d value %h", k, v);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            if (k !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, k);
                mismatch_count++;
            end
            if (v !== want.value)
            begin
                $error("value: expected %h, got %h", want.value, v);
                mismatch_count++;
            end
            if (idx !== want.arg_index)
            begin
                $error("arg_index: expected %0d, got %0d", want.arg_index, idx);
                mismatch_count++;
            end
            if (st !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                mismatch_count++;
            end
            if (rl !== want.run_last)
            begin
                $error("run_last: expected %0d, got %0d", want.run_last, rl);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic [7:0]  data_byte;
    logic        packet_end;
    logic        push;
    logic        full;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [3:0]  arg_index;
    logic [2:0]  status;
    logic        run_last;
    logic        empty;
    logic        pop;

    osc_result_board_t sb = new();
    logic [7:0] msg_bytes[$];
    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int packets_sent;

    osc_message_decoder_core #(.MAX_TAGS(TAG_SLOTS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .packet_end (packet_end),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .value      (value),
        .arg_index  (arg_index),
        .status     (status),
        .run_last   (run_last),
        .empty      (empty),
        .pop        (pop)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Message building
    function automatic void add_byte(logic [7:0] b);
        msg_bytes = {msg_bytes, b};
    endfunction

    function automatic void push_word(logic [31:0] w);
        add_byte(w[31:24]);
        add_byte(w[23:16]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endfunction

    // Padding content is random, the decoder must not look at it
    function automatic void pad_word();
        while (msg_bytes.size() % 4 != 0) add_byte(8'($urandom));
    endfunction

    // Mostly well-formed messages with random content; some noise, cut or corrupted
    function automatic void make_random_message();
        logic [7:0]  tag_list[$];
        logic [7:0]  tc;
        logic [31:0] w;
        int          n_tags;
        int          roll;
        int          cut;
        bit          stop;
        msg_bytes.delete();
        if ($urandom_range(0, 99) < 10)
        begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
            return;
        end

        add_byte(omd_pkg::CHAR_SLASH);
        repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(1, 255)));
        add_byte(8'h00);
        pad_word();

        roll = $urandom_range(0, 99);
        if (roll < 80) n_tags = $urandom_range(0, 5);
        else if (roll < 95) n_tags = $urandom_range(6, TAG_SLOTS);
        else n_tags = $urandom_range(TAG_SLOTS + 1, TAG_SLOTS + 3);
        add_byte(omd_pkg::CHAR_COMMA);
        repeat (n_tags)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3) tc = 8'($urandom_range(1, 255));
            else
            begin
                case (roll % 6)
                    0:       tc = omd_pkg::CHAR_LC_F;
                    1:       tc = omd_pkg::CHAR_LC_I;
                    2:       tc = omd_pkg::CHAR_LC_S;
                    3:       tc = omd_pkg::CHAR_UC_T;
                    4:       tc = omd_pkg::CHAR_UC_F;
                    default: tc = omd_pkg::CHAR_LC_B;
                endcase
            end
            tag_list = {tag_list, tc};
            add_byte(tc);
        end
        add_byte(8'h00);
        pad_word();

        // Arguments in tag order
        stop = 1'b0;
        foreach (tag_list[i])
        begin
            if (!stop)
            begin
                case (tag_list[i])
                    omd_pkg::CHAR_LC_I, omd_pkg::CHAR_LC_F:
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 10) w = '0;
                        else if (roll < 20) w = '1;
                        else w = $urandom;
                        push_word(w);
                    end
                    omd_pkg::CHAR_LC_S:
                    begin
                        repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(1, 255)));
                        add_byte(8'h00);
                        pad_word();
                    end
                    omd_pkg::CHAR_LC_B:
                    begin
                        if ($urandom_range(0, 99) < 8)
                        begin
                            // huge or oversized length: the packet can only end inside it
                            case ($urandom_range(0, 3))
                                0:       w = omd_pkg::BLOB_LEN_MAX;
                                1:       w = omd_pkg::BLOB_LEN_MAX + 32'd1;
                                2:       w = '1;
                                default: w = $urandom;
                            endcase
                            push_word(w);
                            repeat ($urandom_range(0, 5)) add_byte(8'($urandom));
                            stop = 1'b1;
                        end
                        else
                        begin
                            w = $urandom_range(0, 7);
                            push_word(w);
                            repeat (w) add_byte(8'($urandom));
                            pad_word();
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (!stop && $urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom));

        // Early end and corrupted bytes
        if (msg_bytes.size() > 1 && $urandom_range(0, 99) < 12)
        begin
            cut = $urandom_range(1, msg_bytes.size() - 1);
            msg_bytes = msg_bytes[0:cut - 1];
        end
        if ($urandom_range(0, 99) < 6)
            msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
    endfunction

    // One input transfer; returns at the falling edge after acceptance
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        packet_end <= last;
        do @(posedge clk); while (full);
        sb.note_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_message();
        foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        packets_sent++;
    endtask

    // Hold the sender until every predicted result has been popped
    task automatic hold_until_drained();
        push <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    task automatic run_random_phase(int snd_pct, int rcv_pct);
        int start;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start = bytes_sent;
        while (bytes_sent - start < BYTES_PER_PHASE)
        begin
            make_random_message();
            send_message();
        end
        hold_until_drained();
    endtask

    task automatic run_directed();
        // bundle marker and NUL as first byte: bad address
        msg_bytes = '{8'h23};
        send_message();
        msg_bytes = '{8'h00};
        send_message();
        // packet ends right after the padded address: ok
        msg_bytes = '{omd_pkg::CHAR_SLASH, 8'h61, 8'h62, 8'h00};
        send_message();
        // tag string without the comma
        msg_bytes = '{omd_pkg::CHAR_SLASH, 8'h00, 8'h00, 8'h00, omd_pkg::CHAR_LC_S};
        send_message();
        // unknown tag, found when the walk reaches it
        msg_bytes = '{omd_pkg::CHAR_SLASH, 8'h00, 8'h00, 8'h00,
                      omd_pkg::CHAR_COMMA, 8'h71, 8'h00, 8'h00};
        send_message();
        // blob length above the limit, later bytes ignored
        msg_bytes = '{omd_pkg::CHAR_SLASH, 8'h00, 8'h00, 8'h00,
                      omd_pkg::CHAR_COMMA, omd_pkg::CHAR_LC_B, 8'h00, 8'h00,
                      8'hFF, 8'hFF, 8'hFF, 8'hFD, 8'h55};
        send_message();
        // one tag more than the store holds
        msg_bytes = '{omd_pkg::CHAR_SLASH, 8'h00, 8'h00, 8'h00, omd_pkg::CHAR_COMMA};
        repeat (TAG_SLOTS + 1) add_byte(omd_pkg::CHAR_LC_F);
        send_message();
        // T and F walked on the byte that ends the packet
        msg_bytes = '{omd_pkg::CHAR_SLASH, 8'h00, 8'h00, 8'h00,
                      omd_pkg::CHAR_COMMA, omd_pkg::CHAR_UC_T, omd_pkg::CHAR_UC_F, 8'h00};
        send_message();
        // every argument kind, extreme values, then a trailing byte
        msg_bytes = '{omd_pkg::CHAR_SLASH, 8'hFF, 8'h01, 8'h00,
                      omd_pkg::CHAR_COMMA, omd_pkg::CHAR_LC_I,
                      omd_pkg::CHAR_UC_T, omd_pkg::CHAR_UC_F,
                      omd_pkg::CHAR_LC_F, omd_pkg::CHAR_LC_S,
                      omd_pkg::CHAR_LC_B, 8'h00,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h00, 8'h00, 8'h00, 8'h00,
                      8'h41, 8'h00, 8'hAA, 8'h55,
                      8'h00, 8'h00, 8'h00, 8'h01,
                      8'h5A, 8'hA5, 8'hFF, 8'h00,
                      8'hC3};
        send_message();
    endtask

    // Result side: random pop, check on each accepted transfer
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result(kind, value, arg_index, status, run_last);
            @(negedge clk);
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        data_byte = 8'h00;
        packet_end = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 45;
        bytes_sent = 0;
        packets_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        hold_until_drained();
        run_random_phase(27, 45);
        run_random_phase(45, 27);
        run_random_phase(0, 0);

        // extra cycles catch results nobody predicted
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d packets, %0d byte transfers, %0d results checked",
                 packets_sent, bytes_sent, sb.checked_count);
        $display("statuses: ok %0d, truncated %0d, bad address %0d, bad tags %0d, %s %0d, %s %0d",
                 sb.status_tally[omd_pkg::ST_OK], sb.status_tally[omd_pkg::ST_TRUNCATED],
                 sb.status_tally[omd_pkg::ST_BAD_ADDR], sb.status_tally[omd_pkg::ST_BAD_TAGS],
                 "unknown", sb.status_tally[omd_pkg::ST_UNKNOWN],
                 "too many", sb.status_tally[omd_pkg::ST_TOO_MANY]);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
